@@ rtl/iwg_pkg.sv @@
// ----------------------------------------------------------------------------
// iwg_pkg
// Shared constants, register codes and types of the im2col window gather.
// ----------------------------------------------------------------------------
package iwg_pkg;

  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned MAX_HEIGHT   = 64;
  localparam int unsigned MAX_WIDTH    = 64;
  localparam int unsigned MAX_KERNEL   = 8;
  localparam int unsigned PIXEL_WIDTH  = 16;

  localparam int unsigned CH_W        = $clog2(MAX_CHANNELS);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned STORE_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned STORE_AW    = CH_W + ROW_W + COL_W;
  localparam int unsigned KDIM_W      = $clog2(MAX_KERNEL);

  // Image size register width and signed window coordinate width.
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned POS_W  = 13;
  localparam int unsigned PROD_W = POS_W - 1;
  localparam int unsigned MC_W   = 8;
  localparam int unsigned TAPS_W = 7;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [2:0] {
    REG_KERNEL_SHAPE = 3'd0,
    REG_STRIDE       = 3'd1,
    REG_PADDING      = 3'd2,
    REG_DILATION     = 3'd3,
    REG_HEIGHT       = 3'd4,
    REG_WIDTH        = 3'd5
  } iwg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_GATHER = 1'b1
  } iwg_op_e;

  // Decoded configuration, valid while the block is idle and during gathers.
  typedef struct packed {
    logic [KDIM_W-1:0] kh_m1;
    logic [KDIM_W-1:0] kw_m1;
    logic [4:0]        sh;
    logic [4:0]        sw;
    logic [3:0]        ph;
    logic [3:0]        pw;
    logic [4:0]        dh;
    logic [4:0]        dw;
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] w;
    logic [TAPS_W-1:0] taps;
  } iwg_cfg_t;

  // One queued request. For writes pos_h/pos_w hold the pixel position, for
  // gathers the top-left corner of the window, which may lie in padding.
  typedef struct packed {
    iwg_op_e                 op;
    logic [CH_W-1:0]         ch;
    logic signed [POS_W-1:0] pos_h;
    logic signed [POS_W-1:0] pos_w;
    logic [MC_W-1:0]         mc_base;
    logic [PIXEL_WIDTH-1:0]  pixel;
  } iwg_cmd_t;

endpackage

@@ rtl/iwg_in_if.sv @@
// ----------------------------------------------------------------------------
// iwg_in_if
// Request channel: pixel writes and gather requests.
// ----------------------------------------------------------------------------
interface iwg_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [1:0]         channel;
  logic [6:0]         row;
  logic [6:0]         column;
  logic signed [15:0] pixel_value;

  modport source (output valid, command, channel, row, column, pixel_value,
                  input ready);
  modport sink   (input valid, command, channel, row, column, pixel_value,
                  output ready);
endinterface

@@ rtl/iwg_out_if.sv @@
// ----------------------------------------------------------------------------
// iwg_out_if
// Result channel: gathered taps, one per kernel tap of each gather request.
// ----------------------------------------------------------------------------
interface iwg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tap_value;
  logic [7:0]         matrix_channel;
  logic [2:0]         tap_row;
  logic [2:0]         tap_col;
  logic               from_padding;
  logic               last_tap;

  modport source (output valid, tap_value, matrix_channel, tap_row, tap_col,
                  from_padding, last_tap, input ready);
  modport sink   (input valid, tap_value, matrix_channel, tap_row, tap_col,
                  from_padding, last_tap, output ready);
endinterface

@@ rtl/iwg_regs.sv @@
// ----------------------------------------------------------------------------
// iwg_regs
// APB register file holding the geometry registers, with decoded outputs.
// ----------------------------------------------------------------------------
module iwg_regs
  import iwg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output iwg_cfg_t          cfg_o
);

  logic [7:0]        kernel_q, stride_q, padding_q, dilation_q;
  logic [SIZE_W-1:0] height_q, width_q;
  iwg_reg_e          reg_idx;
  logic              wr_en;
  logic [3:0]        kh, kw;

  assign reg_idx = iwg_reg_e'(paddr[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q   <= 8'h22;
      stride_q   <= 8'h00;
      padding_q  <= 8'h11;
      dilation_q <= 8'h00;
      height_q   <= SIZE_W'(MAX_HEIGHT);
      width_q    <= SIZE_W'(MAX_WIDTH);
    end else if (wr_en) begin
      case (reg_idx)
        REG_KERNEL_SHAPE: kernel_q   <= pwdata[7:0];
        REG_STRIDE:       stride_q   <= pwdata[7:0];
        REG_PADDING:      padding_q  <= pwdata[7:0];
        REG_DILATION:     dilation_q <= pwdata[7:0];
        REG_HEIGHT:       height_q   <= pwdata[SIZE_W-1:0];
        REG_WIDTH:        width_q    <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KERNEL_SHAPE: prdata = APB_DW'(kernel_q);
      REG_STRIDE:       prdata = APB_DW'(stride_q);
      REG_PADDING:      prdata = APB_DW'(padding_q);
      REG_DILATION:     prdata = APB_DW'(dilation_q);
      REG_HEIGHT:       prdata = APB_DW'(height_q);
      REG_WIDTH:        prdata = APB_DW'(width_q);
      default:          prdata = '0;
    endcase
  end

  // Kernel sizes saturate at the largest supported kernel.
  always_comb begin
    cfg_o.kh_m1 = (kernel_q[3:0] >= 4'(MAX_KERNEL - 1)) ? KDIM_W'(MAX_KERNEL - 1)
                                                        : kernel_q[KDIM_W-1:0];
    cfg_o.kw_m1 = (kernel_q[7:4] >= 4'(MAX_KERNEL - 1)) ? KDIM_W'(MAX_KERNEL - 1)
                                                        : kernel_q[KDIM_W+3:4];
    cfg_o.sh    = {1'b0, stride_q[3:0]} + 5'd1;
    cfg_o.sw    = {1'b0, stride_q[7:4]} + 5'd1;
    cfg_o.ph    = padding_q[3:0];
    cfg_o.pw    = padding_q[7:4];
    cfg_o.dh    = {1'b0, dilation_q[3:0]} + 5'd1;
    cfg_o.dw    = {1'b0, dilation_q[7:4]} + 5'd1;
    cfg_o.h     = (height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_q;
    cfg_o.w     = (width_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_q;
    kh          = 4'(cfg_o.kh_m1) + 4'd1;
    kw          = 4'(cfg_o.kw_m1) + 4'd1;
    cfg_o.taps  = TAPS_W'(kh) * TAPS_W'(kw);
  end

endmodule

@@ rtl/iwg_front.sv @@
// ----------------------------------------------------------------------------
// iwg_front
// Accepts requests, drops writes outside the image and precomputes the
// window origin and column-matrix base of gathers.
// ----------------------------------------------------------------------------
module iwg_front
  import iwg_pkg::*;
(
  iwg_in_if.sink    item,
  input  iwg_cfg_t  cfg_i,
  input  logic      full_i,
  output logic      push_o,
  output iwg_cmd_t  cmd_o
);

  logic [PROD_W-1:0] prod_h, prod_w;
  logic [8:0]        mc_prod;
  logic              in_image;
  iwg_op_e           op;

  assign op         = iwg_op_e'(item.command);
  assign item.ready = !full_i;
  assign in_image   = (item.row < cfg_i.h) && (item.column < cfg_i.w);
  assign push_o     = item.valid && !full_i && ((op == OP_GATHER) || in_image);

  assign prod_h  = PROD_W'(item.row) * PROD_W'(cfg_i.sh);
  assign prod_w  = PROD_W'(item.column) * PROD_W'(cfg_i.sw);
  assign mc_prod = 9'(item.channel) * 9'(cfg_i.taps);

  always_comb begin
    cmd_o.op      = op;
    cmd_o.ch      = item.channel;
    cmd_o.mc_base = mc_prod[MC_W-1:0];
    cmd_o.pixel   = item.pixel_value;
    if (op == OP_GATHER) begin
      cmd_o.pos_h = $signed({1'b0, prod_h}) - $signed(POS_W'(cfg_i.ph));
      cmd_o.pos_w = $signed({1'b0, prod_w}) - $signed(POS_W'(cfg_i.pw));
    end else begin
      cmd_o.pos_h = POS_W'(item.row);
      cmd_o.pos_w = POS_W'(item.column);
    end
  end

endmodule

@@ rtl/iwg_fifo.sv @@
// ----------------------------------------------------------------------------
// iwg_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module iwg_fifo
  import iwg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  iwg_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output iwg_cmd_t cmd_o
);

  iwg_cmd_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
    end
  end

endmodule

@@ rtl/iwg_back.sv @@
// ----------------------------------------------------------------------------
// iwg_back
// Pixel store and tap sequencer: does writes and walks gather windows, one tap
// per cycle unless stalled, through a store read stage and an output register.
// ----------------------------------------------------------------------------
module iwg_back
  import iwg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  iwg_cfg_t cfg_i,
  input  logic     cmd_valid_i,
  input  iwg_cmd_t cmd_i,
  output logic     pop_o,
  iwg_out_if.source tap
);

  logic [PIXEL_WIDTH-1:0]  store_q [STORE_DEPTH];
  logic [PIXEL_WIDTH-1:0]  rd_data_q;

  // Sequencer state.
  logic                    busy_q;
  logic [KDIM_W-1:0]       ky_q, kx_q;
  logic signed [POS_W-1:0] ih_q, iw_q, base_w_q;
  logic [CH_W-1:0]         ch_q;
  logic [MC_W-1:0]         mc_q;

  // Read stage sideband.
  logic                    s1_valid_q, s1_pad_q, s1_last_q;
  logic [KDIM_W-1:0]       s1_ky_q, s1_kx_q;
  logic [MC_W-1:0]         s1_mc_q;

  // Output register.
  logic                    out_valid_q, out_pad_q, out_last_q;
  logic [KDIM_W-1:0]       out_ky_q, out_kx_q;
  logic [MC_W-1:0]         out_mc_q;
  logic [PIXEL_WIDTH-1:0]  out_val_q;

  logic s2_free, s1_free, issue, last_now, pad_now, start, wr_en, row_end;
  logic [STORE_AW-1:0] rd_addr, wr_addr;

  assign s2_free  = !out_valid_q || tap.ready;
  assign s1_free  = !s1_valid_q || s2_free;
  assign issue    = busy_q && s1_free;
  assign row_end  = (kx_q == cfg_i.kw_m1);
  assign last_now = row_end && (ky_q == cfg_i.kh_m1);
  assign pop_o    = cmd_valid_i && (!busy_q || (issue && last_now));
  assign start    = pop_o && (cmd_i.op == OP_GATHER);
  assign wr_en    = pop_o && (cmd_i.op == OP_WRITE);

  // A negative coordinate has its sign bit set; the rest is compared unsigned.
  assign pad_now = ih_q[POS_W-1] || iw_q[POS_W-1]
                || (ih_q[POS_W-2:0] >= (POS_W - 1)'(cfg_i.h))
                || (iw_q[POS_W-2:0] >= (POS_W - 1)'(cfg_i.w));

  assign rd_addr = {ch_q, ih_q[ROW_W-1:0], iw_q[COL_W-1:0]};
  assign wr_addr = {cmd_i.ch, cmd_i.pos_h[ROW_W-1:0], cmd_i.pos_w[COL_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= cmd_i.pixel;
    end
    if (issue) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start) begin
      busy_q <= 1'b1;
    end else if (issue && last_now) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      ky_q     <= '0;
      kx_q     <= '0;
      ih_q     <= cmd_i.pos_h;
      iw_q     <= cmd_i.pos_w;
      base_w_q <= cmd_i.pos_w;
      ch_q     <= cmd_i.ch;
      mc_q     <= cmd_i.mc_base;
    end else if (issue) begin
      mc_q <= mc_q + 1'b1;
      if (row_end) begin
        kx_q <= '0;
        ky_q <= ky_q + 1'b1;
        iw_q <= base_w_q;
        ih_q <= ih_q + POS_W'(cfg_i.dh);
      end else begin
        kx_q <= kx_q + 1'b1;
        iw_q <= iw_q + POS_W'(cfg_i.dw);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s2_free) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s2_free) begin
        out_valid_q <= 1'b1;
      end else if (tap.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_pad_q  <= pad_now;
      s1_last_q <= last_now;
      s1_ky_q   <= ky_q;
      s1_kx_q   <= kx_q;
      s1_mc_q   <= mc_q;
    end
    if (s1_valid_q && s2_free) begin
      out_pad_q  <= s1_pad_q;
      out_last_q <= s1_last_q;
      out_ky_q   <= s1_ky_q;
      out_kx_q   <= s1_kx_q;
      out_mc_q   <= s1_mc_q;
      out_val_q  <= s1_pad_q ? '0 : rd_data_q;
    end
  end

  assign tap.valid          = out_valid_q;
  assign tap.tap_value      = out_val_q;
  assign tap.matrix_channel = out_mc_q;
  assign tap.tap_row        = out_ky_q;
  assign tap.tap_col        = out_kx_q;
  assign tap.from_padding   = out_pad_q;
  assign tap.last_tap       = out_last_q;

`ifndef SYNTHESIS
  a_seq_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !issue |=> $stable(ky_q) && $stable(kx_q) && $stable(mc_q))
    else $error("tap sequencer advanced without issuing a tap");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && last_now && !start |=> !busy_q)
    else $error("gather still busy after its last tap");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_free |=> s1_valid_q && $stable(s1_mc_q) && $stable(s1_pad_q))
    else $error("read stage lost a tap while the output stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_pad_q |-> out_val_q == '0)
    else $error("padding tap carries a nonzero value");
`endif

endmodule

@@ rtl/im2col_window_gather.sv @@
// ----------------------------------------------------------------------------
// im2col_window_gather
// Convolution unfold over a stored image: pixel writes fill the store,
// gather requests emit one column-matrix entry per kernel tap.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | carries
//   item_i   | in        | valid/ready          | command, channel, row, column, pixel
//   tap_o    | out       | valid/ready          | tap value, matrix row, kernel pos, flags
//   APB      | in        | psel/penable, pready | geometry register writes and reads
//
// A write goes into the store as it is popped; a gather emits kh*kw taps,
// issued in turn by the tap sequencer through the single store read port.
// With an empty queue and an idle back end the first tap of a gather is offered
// after the queue entry, the sequencer state, the read stage and output register.
// A four-entry request queue lets the front keep accepting while the back
// works or the output stalls; the store needs no clearing after reset.
// ----------------------------------------------------------------------------
module im2col_window_gather
  import iwg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  iwg_in_if.sink            item_i,
  iwg_out_if.source         tap_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  iwg_cfg_t cfg;
  iwg_cmd_t front_cmd, queue_cmd;
  logic     push, full, queue_valid, pop;

  iwg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iwg_front u_front (
    .item   (item_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  iwg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  iwg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .tap         (tap_o)
  );

endmodule
